>>> hw/rtl/xpr_pkg.sv
// Package for the XOR parity packet recovery block.
// Holds sizes, codes, transaction structs and the controller/datapath links.
// Depends on nothing.
package xpr_pkg;

	// Default sizes of the group storage.
	localparam int unsigned MAX_DATA_PACKETS   = 16;
	localparam int unsigned MAX_PARITY_PACKETS = 4;
	localparam int unsigned MAX_PACKET_BYTES   = 2048;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DATA_PER_GROUP   = 2'd0,
		REG_PARITY_PER_GROUP = 2'd1
	} reg_idx_t;

	// Request operation codes.
	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_RECOVER = 2'd1,
		OP_READ    = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [3:0] {
		ST_ACCEPTED  = 4'd0,
		ST_IGNORED   = 4'd1,
		ST_COMPLETE  = 4'd2,
		ST_RECOVERED = 4'd3,
		ST_TOO_FEW   = 4'd4,
		ST_UNRECOV   = 4'd5,
		ST_READ_OK   = 4'd6,
		ST_EMPTY     = 4'd7,
		ST_CLEARED   = 4'd8
	} status_t;

	// Packet write mode between and during packets.
	typedef enum logic [1:0] {
		WM_IDLE    = 2'd0,
		WM_DATA    = 2'd1,
		WM_PARITY  = 2'd2,
		WM_DISCARD = 2'd3
	} wmode_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] seq;
		logic        is_parity;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [3:0]  read_slot;
		logic [10:0] read_offset;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [7:0]  read_data;
		logic [11:0] packet_length;
		logic [3:0]  rebuilt_slot;
		logic        overflow;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic mod_start;
		logic mod_step;
		logic open_pkt;
		logic do_byte;
		logic rd_req;
		logic rd_res;
		logic chk_res;
		logic scan_start;
		logic scan_step;
		logic unrec_res;
		logic par_req;
		logic dat_step;
		logic wr_byte;
		logic rb_done;
		logic clr;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic wmode_idle;
		logic mod_done;
		logic recov_go;
		logic scan_last;
		logic scan_found;
		logic plen_zero;
		logic dat_last;
		logic j_last;
		logic out_free;
	} sts_t;

endpackage

>>> hw/rtl/xpr_ctrl.sv
// Controller state machine of the XOR parity packet recovery block.
// Sequences each transaction through the datapath; uses xpr_pkg.
module xpr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic [1:0]    req_op,
	output logic          req_stall,
	input  xpr_pkg::sts_t sts,
	output xpr_pkg::cmd_t cmd
);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_MOD   = 14'b00000000000010,
		S_BYTE  = 14'b00000000000100,
		S_RDREQ = 14'b00000000001000,
		S_RDRES = 14'b00000000010000,
		S_RCHK  = 14'b00000000100000,
		S_SCAN  = 14'b00000001000000,
		S_SCHK  = 14'b00000010000000,
		S_RPAR  = 14'b00000100000000,
		S_RDAT  = 14'b00001000000000,
		S_RWR   = 14'b00010000000000,
		S_RDONE = 14'b00100000000000,
		S_CLR   = 14'b01000000000000,
		S_FIN   = 14'b10000000000000
	} state_t;

	state_t st_q;
	state_t st_nx;

	// One transaction at a time: take requests only when idle.
	assign req_stall = (st_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		cmd   = '0;
		st_nx = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					unique case (xpr_pkg::op_t'(req_op))
						xpr_pkg::OP_BYTE: begin
							if (sts.wmode_idle) begin
								cmd.mod_start = 1'b1;
								st_nx = S_MOD;
							end else begin
								st_nx = S_BYTE;
							end
						end
						xpr_pkg::OP_RECOVER: st_nx = S_RCHK;
						xpr_pkg::OP_READ:    st_nx = S_RDREQ;
						xpr_pkg::OP_CLEAR:   st_nx = S_CLR;
					endcase
				end
			end
			S_MOD: begin
				if (sts.mod_done) begin
					cmd.open_pkt = 1'b1;
					st_nx = S_BYTE;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			S_BYTE: begin
				cmd.do_byte = 1'b1;
				st_nx = S_FIN;
			end
			S_RDREQ: begin
				cmd.rd_req = 1'b1;
				st_nx = S_RDRES;
			end
			S_RDRES: begin
				cmd.rd_res = 1'b1;
				st_nx = S_FIN;
			end
			S_RCHK: begin
				if (sts.recov_go) begin
					cmd.scan_start = 1'b1;
					st_nx = S_SCAN;
				end else begin
					cmd.chk_res = 1'b1;
					st_nx = S_FIN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					st_nx = S_SCHK;
				end
			end
			S_SCHK: begin
				if (!sts.scan_found) begin
					cmd.unrec_res = 1'b1;
					st_nx = S_FIN;
				end else if (sts.plen_zero) begin
					st_nx = S_RDONE;
				end else begin
					st_nx = S_RPAR;
				end
			end
			S_RPAR: begin
				cmd.par_req = 1'b1;
				st_nx = S_RDAT;
			end
			S_RDAT: begin
				cmd.dat_step = 1'b1;
				if (sts.dat_last) begin
					st_nx = S_RWR;
				end
			end
			S_RWR: begin
				cmd.wr_byte = 1'b1;
				st_nx = sts.j_last ? S_RDONE : S_RPAR;
			end
			S_RDONE: begin
				cmd.rb_done = 1'b1;
				st_nx = S_FIN;
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				st_nx = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					st_nx = S_IDLE;
				end
			end
			default: st_nx = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

endmodule

>>> hw/rtl/xpr_datapath.sv
// Datapath of the XOR parity packet recovery block: group storage, slot
// remainder unit, rebuild accumulator and result registers. Uses xpr_pkg.
module xpr_datapath #(
	parameter int unsigned MAX_DATA_PACKETS   = xpr_pkg::MAX_DATA_PACKETS,
	parameter int unsigned MAX_PARITY_PACKETS = xpr_pkg::MAX_PARITY_PACKETS,
	parameter int unsigned MAX_PACKET_BYTES   = xpr_pkg::MAX_PACKET_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  xpr_pkg::req_t                  req,
	input  logic                           cfg_we,
	input  logic [xpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [xpr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  xpr_pkg::cmd_t                  cmd,
	output xpr_pkg::sts_t                  sts,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output xpr_pkg::rsp_t                  rsp
);

	localparam int unsigned DP  = MAX_DATA_PACKETS;
	localparam int unsigned PP  = MAX_PARITY_PACKETS;
	localparam int unsigned PB  = MAX_PACKET_BYTES;
	localparam int unsigned DSW = (DP > 1) ? $clog2(DP) : 1;
	localparam int unsigned PSW = (PP > 1) ? $clog2(PP) : 1;
	localparam int unsigned SW  = (DSW > PSW) ? DSW : PSW;
	localparam int unsigned LW  = $clog2(PB + 1);
	localparam int unsigned DAW = $clog2(DP * PB);
	localparam int unsigned PAW = $clog2(PP * PB);
	localparam int unsigned CW  = $clog2(DP + 1);
	localparam int unsigned PCW = $clog2(PP + 1);

	// Configuration and group bookkeeping.
	logic [4:0]      kreg_q;
	logic [2:0]      mreg_q;
	logic [DP-1:0]   dpres_q;
	logic [LW-1:0]   dlen_q [DP];
	logic [PP-1:0]   ppres_q;
	logic [LW-1:0]   plen_q [PP];
	logic [CW-1:0]   drcv_q;
	logic [PCW-1:0]  prcv_q;
	logic [SW-1:0]   wslot_q;
	logic [LW-1:0]   wpos_q;
	xpr_pkg::wmode_t wmode_q;
	logic            rsp_valid_q;

	// Working registers.
	xpr_pkg::req_t   item_q;
	logic [7:0]      rem_q;
	logic [31:0]     sh_q;
	logic [5:0]      cnt_q;
	logic [DSW-1:0]  si_q;
	logic            found_q;
	logic [DSW-1:0]  miss_q;
	logic [LW-1:0]   j_q;
	logic [DSW-1:0]  di_q;
	logic [7:0]      acc_q;
	logic            dv_q;
	logic [7:0]      drd_q;
	logic [7:0]      prd_q;
	xpr_pkg::rsp_t   res_q;
	xpr_pkg::rsp_t   rsp_q;

	// Memories.
	logic [7:0] dmem [DP*PB];
	logic [7:0] pmem [PP*PB];

	// Combinational helpers.
	logic [6:0]     k_wide;
	logic [4:0]     m_wide;
	logic [7:0]     k_eff;
	logic [7:0]     m_eff;
	logic [7:0]     divisor;
	logic [7:0]     rem_t;
	logic           pos_ok;
	logic           writing;
	logic [LW-1:0]  pos_nx;
	logic [7:0]     rs_w;
	logic           rd_hit;
	logic [LW-1:0]  rd_len;
	logic           rd_in;
	logic [7:0]     dr_w;
	logic [7:0]     pr_w;
	logic           dwe;
	logic [DAW-1:0] dwa;
	logic [7:0]     dwd;
	logic           dre;
	logic [DAW-1:0] dra;
	logic           pwe;
	logic [PAW-1:0] pwa;
	logic           group_clr;

	// Saturated group sizes.
	always_comb begin
		k_wide = 7'(kreg_q);
		if (k_wide == 7'd0) begin
			k_wide = 7'd1;
		end else if (k_wide > 7'(DP)) begin
			k_wide = 7'(DP);
		end
		m_wide = 5'(mreg_q);
		if (m_wide == 5'd0) begin
			m_wide = 5'd1;
		end else if (m_wide > 5'(PP)) begin
			m_wide = 5'(PP);
		end
	end
	assign k_eff = 8'(k_wide);
	assign m_eff = 8'(m_wide);

	// Bit-serial remainder of seq by the slot count.
	assign divisor = item_q.is_parity ? m_eff : k_eff;
	assign rem_t   = {rem_q[6:0], sh_q[31]};

	// Packet byte handling.
	assign pos_ok  = (wpos_q < LW'(PB));
	assign writing = (wmode_q == xpr_pkg::WM_DATA) || (wmode_q == xpr_pkg::WM_PARITY);
	assign pos_nx  = (writing && pos_ok) ? wpos_q + LW'(1) : wpos_q;

	// Read request checks.
	assign rs_w   = 8'(item_q.read_slot);
	assign rd_hit = (rs_w < k_eff) && (rs_w < 8'(DP)) && dpres_q[rs_w[DSW-1:0]];
	assign rd_len = dlen_q[rs_w[DSW-1:0]];
	assign rd_in  = 16'(item_q.read_offset) < 16'(rd_len);

	// Recovery outcome checks.
	assign dr_w = 8'(drcv_q);
	assign pr_w = 8'(prcv_q);

	assign group_clr = cmd.clr || (cfg_we &&
		((cfg_index == xpr_pkg::REG_DATA_PER_GROUP) ||
		 (cfg_index == xpr_pkg::REG_PARITY_PER_GROUP)));

	// Status to the controller.
	always_comb begin
		sts            = '0;
		sts.wmode_idle = (wmode_q == xpr_pkg::WM_IDLE);
		sts.mod_done   = (cnt_q == 6'd32);
		sts.recov_go   = (dr_w != k_eff) && ((dr_w + pr_w) >= k_eff) &&
			(m_eff == 8'd1) && (pr_w == 8'd1) && ((dr_w + 8'd1) == k_eff) && ppres_q[0];
		sts.scan_last  = (8'(si_q) == (k_eff - 8'd1));
		sts.scan_found = found_q;
		sts.plen_zero  = (plen_q[0] == '0);
		sts.dat_last   = (8'(di_q) == (k_eff - 8'd1));
		sts.j_last     = (j_q == (plen_q[0] - LW'(1)));
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	// Memory port selection.
	always_comb begin
		dwe = 1'b0;
		dwa = '0;
		dwd = '0;
		pwe = 1'b0;
		pwa = '0;
		dre = 1'b0;
		dra = '0;
		if (cmd.do_byte && pos_ok) begin
			if (wmode_q == xpr_pkg::WM_DATA) begin
				dwe = 1'b1;
				dwa = DAW'(wslot_q) * DAW'(PB) + DAW'(wpos_q);
			end else if (wmode_q == xpr_pkg::WM_PARITY) begin
				pwe = 1'b1;
				pwa = PAW'(wslot_q) * PAW'(PB) + PAW'(wpos_q);
			end
			dwd = item_q.data_byte;
		end
		if (cmd.wr_byte) begin
			dwe = 1'b1;
			dwa = DAW'(miss_q) * DAW'(PB) + DAW'(j_q);
			dwd = acc_q ^ (dv_q ? drd_q : 8'h00);
		end
		if (cmd.rd_req) begin
			dre = 1'b1;
			dra = DAW'(rs_w[DSW-1:0]) * DAW'(PB) + DAW'(item_q.read_offset);
		end
		if (cmd.dat_step) begin
			dre = 1'b1;
			dra = DAW'(di_q) * DAW'(PB) + DAW'(j_q);
		end
	end

	// Data store.
	always_ff @(posedge clk) begin
		if (dwe) begin
			dmem[dwa] <= dwd;
		end
		if (dre) begin
			drd_q <= dmem[dra];
		end
	end

	// Parity store; recovery reads the first parity slot only.
	always_ff @(posedge clk) begin
		if (pwe) begin
			pmem[pwa] <= item_q.data_byte;
		end
		if (cmd.par_req) begin
			prd_q <= pmem[PAW'(j_q)];
		end
	end

	// Group state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kreg_q  <= 5'd4;
			mreg_q  <= 3'd1;
			dpres_q <= '0;
			ppres_q <= '0;
			for (int i = 0; i < DP; i++) dlen_q[i] <= '0;
			for (int i = 0; i < PP; i++) plen_q[i] <= '0;
			drcv_q  <= '0;
			prcv_q  <= '0;
			wslot_q <= '0;
			wpos_q  <= '0;
			wmode_q <= xpr_pkg::WM_IDLE;
		end else begin
			if (cfg_we && (cfg_index == xpr_pkg::REG_DATA_PER_GROUP)) begin
				kreg_q <= cfg_data[4:0];
			end
			if (cfg_we && (cfg_index == xpr_pkg::REG_PARITY_PER_GROUP)) begin
				mreg_q <= cfg_data[2:0];
			end
			if (group_clr) begin
				dpres_q <= '0;
				ppres_q <= '0;
				for (int i = 0; i < DP; i++) dlen_q[i] <= '0;
				for (int i = 0; i < PP; i++) plen_q[i] <= '0;
				drcv_q  <= '0;
				prcv_q  <= '0;
				wslot_q <= '0;
				wpos_q  <= '0;
				wmode_q <= xpr_pkg::WM_IDLE;
			end
			// Open a packet at its first byte.
			if (cmd.open_pkt) begin
				wslot_q <= SW'(rem_q);
				wpos_q  <= '0;
				if (item_q.is_parity) begin
					wmode_q <= ppres_q[rem_q[PSW-1:0]] ? xpr_pkg::WM_DISCARD : xpr_pkg::WM_PARITY;
				end else begin
					wmode_q <= dpres_q[rem_q[DSW-1:0]] ? xpr_pkg::WM_DISCARD : xpr_pkg::WM_DATA;
				end
			end
			// Store a byte and close the packet on its last byte.
			if (cmd.do_byte) begin
				wpos_q <= pos_nx;
				if (item_q.last_byte) begin
					if (wmode_q == xpr_pkg::WM_PARITY) begin
						plen_q[wslot_q[PSW-1:0]]  <= pos_nx;
						ppres_q[wslot_q[PSW-1:0]] <= 1'b1;
						prcv_q <= prcv_q + PCW'(1);
					end else if (wmode_q == xpr_pkg::WM_DATA) begin
						dlen_q[wslot_q[DSW-1:0]]  <= pos_nx;
						dpres_q[wslot_q[DSW-1:0]] <= 1'b1;
						drcv_q <= drcv_q + CW'(1);
					end
					wmode_q <= xpr_pkg::WM_IDLE;
					wpos_q  <= '0;
				end
			end
			// Commit a rebuilt packet.
			if (cmd.rb_done) begin
				dlen_q[miss_q]  <= plen_q[0];
				dpres_q[miss_q] <= 1'b1;
				drcv_q <= drcv_q + CW'(1);
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= req;
		end
		if (cmd.mod_start) begin
			rem_q <= '0;
			sh_q  <= req.seq;
			cnt_q <= '0;
		end
		if (cmd.mod_step) begin
			rem_q <= (rem_t >= divisor) ? rem_t - divisor : rem_t;
			sh_q  <= {sh_q[30:0], 1'b0};
			cnt_q <= cnt_q + 6'd1;
		end
		// Look for the first missing data slot.
		if (cmd.scan_start) begin
			si_q    <= '0;
			found_q <= 1'b0;
			miss_q  <= '0;
			j_q     <= '0;
		end
		if (cmd.scan_step) begin
			if (!dpres_q[si_q] && !found_q) begin
				miss_q  <= si_q;
				found_q <= 1'b1;
			end
			si_q <= si_q + DSW'(1);
		end
		if (cmd.par_req) begin
			di_q <= '0;
		end
		// Fold the present data bytes into the parity byte.
		if (cmd.dat_step) begin
			dv_q <= dpres_q[di_q] && (j_q < dlen_q[di_q]);
			if (di_q == '0) begin
				acc_q <= prd_q;
			end else if (dv_q) begin
				acc_q <= acc_q ^ drd_q;
			end
			di_q <= di_q + DSW'(1);
		end
		if (cmd.wr_byte) begin
			j_q <= j_q + LW'(1);
		end
	end

	// Result of the current transaction.
	always_ff @(posedge clk) begin
		if (cmd.do_byte) begin
			res_q          <= '0;
			res_q.status   <= (wmode_q == xpr_pkg::WM_DISCARD) ?
				xpr_pkg::ST_IGNORED : xpr_pkg::ST_ACCEPTED;
			res_q.overflow <= writing && !pos_ok;
		end
		if (cmd.rd_res) begin
			res_q        <= '0;
			res_q.status <= xpr_pkg::ST_EMPTY;
			if (rd_hit) begin
				res_q.packet_length <= 12'(rd_len);
				if (rd_in) begin
					res_q.status    <= xpr_pkg::ST_READ_OK;
					res_q.read_data <= drd_q;
				end
			end
		end
		if (cmd.chk_res) begin
			res_q <= '0;
			if (dr_w == k_eff) begin
				res_q.status <= xpr_pkg::ST_COMPLETE;
			end else if ((dr_w + pr_w) < k_eff) begin
				res_q.status <= xpr_pkg::ST_TOO_FEW;
			end else begin
				res_q.status <= xpr_pkg::ST_UNRECOV;
			end
		end
		if (cmd.unrec_res) begin
			res_q        <= '0;
			res_q.status <= xpr_pkg::ST_UNRECOV;
		end
		if (cmd.rb_done) begin
			res_q              <= '0;
			res_q.status       <= xpr_pkg::ST_RECOVERED;
			res_q.rebuilt_slot <= 4'(miss_q);
		end
		if (cmd.clr) begin
			res_q        <= '0;
			res_q.status <= xpr_pkg::ST_CLEARED;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hw/rtl/xor_parity_packet_recovery.sv
// Top level of the XOR parity packet recovery block.
// Joins xpr_ctrl and xpr_datapath; uses xpr_pkg.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   xpr_pkg::req_t
//   rsp       out        rsp_valid/rsp_stall   xpr_pkg::rsp_t
//   cfg       in         cfg_we                cfg_index, cfg_data
//
// One transaction is processed at a time; each ends by passing through an output
// register, so the next request is taken while a result still waits.
// Packet byte: the first byte of a packet first runs the bit-serial seq remainder.
// Read, clear and early recover outcomes need no scan or rebuild pass.
// Rebuild: scans for the missing slot, then for each parity byte reads the k data
// slots through the single read port of the data store. No clearing pass after reset.
module xor_parity_packet_recovery #(
	parameter int unsigned MAX_DATA_PACKETS   = xpr_pkg::MAX_DATA_PACKETS,
	parameter int unsigned MAX_PARITY_PACKETS = xpr_pkg::MAX_PARITY_PACKETS,
	parameter int unsigned MAX_PACKET_BYTES   = xpr_pkg::MAX_PACKET_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  xpr_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output xpr_pkg::rsp_t                  rsp,
	input  logic                           cfg_we,
	input  logic [xpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [xpr_pkg::CFG_DATA_W-1:0] cfg_data
);

	xpr_pkg::cmd_t cmd;
	xpr_pkg::sts_t sts;

	// Controller.
	xpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath.
	xpr_datapath #(
		.MAX_DATA_PACKETS   (MAX_DATA_PACKETS),
		.MAX_PARITY_PACKETS (MAX_PARITY_PACKETS),
		.MAX_PACKET_BYTES   (MAX_PACKET_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
